@@ rtl/lcg_random_range_top_defines.svh @@
// Assertion macros for the random range generator.
// Included by files that carry concurrent assertions; expects i_clk and i_rst_n in scope.
`ifndef LCG_RANDOM_RANGE_TOP_DEFINES_SVH
`define LCG_RANDOM_RANGE_TOP_DEFINES_SVH
`ifndef SYNTH
`define LCGRR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LCGRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LCGRR_ASSERT(lbl, prop, msg)
`define LCGRR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/lcgrr_pkg.sv @@
// Shared constants, operation codes, state encoding and unit handshake types
// for the random range generator. No dependencies.
package lcgrr_pkg;

    localparam logic [31:0] LCG_MULT   = 32'h5D58_8B65;
    localparam int          DRAW_SHIFT = 16;
    localparam int          DIGIT_W    = 2;
    localparam int          MUL_STEPS  = 32 / DIGIT_W;
    localparam int          REM_STEPS  = DRAW_SHIFT / DIGIT_W;

    typedef enum logic [1:0] {
        OP_RANGED = 2'd0,
        OP_RAW    = 2'd1,
        OP_SEED   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_MUL,
        S_RSEL,
        S_REM,
        S_ADD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic start;
    } t_unit_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

@@ rtl/lcgrr_if.sv @@
// Valid/ready channel interfaces for the random range generator.
// Depends on nothing; one interface per direction.
interface lcgrr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] bound_a;
    logic signed [31:0] bound_b;
    logic [31:0]        seed_value;

    modport source(output valid, output operation, output bound_a, output bound_b,
                   output seed_value, input ready);
    modport sink(input valid, input operation, input bound_a, input bound_b,
                 input seed_value, output ready);
endinterface

interface lcgrr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] ranged_value;
    logic [31:0]        raw_value;

    modport source(output valid, output ranged_value, output raw_value, input ready);
    modport sink(input valid, input ranged_value, input raw_value, output ready);
endinterface

@@ rtl/lcgrr_mul.sv @@
// Digit-serial multiplier: 32-bit operand times the generator constant, modulo 2^32,
// two operand bits per cycle, most significant first. Uses lcgrr_pkg.
module lcgrr_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lcgrr_pkg::t_unit_ctl i_ctl,
    input  logic [31:0]          i_multiplicand,
    output lcgrr_pkg::t_unit_sts o_sts,
    output logic [31:0]          o_product
);

    localparam int CntW = $clog2(lcgrr_pkg::MUL_STEPS);

    logic [31:0]     r_sh, n_sh;
    logic [31:0]     r_acc, n_acc;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;

    function automatic logic [31:0] mult_digit(input logic [1:0] d);
        logic [31:0] m2;
        m2 = {lcgrr_pkg::LCG_MULT[30:0], 1'b0};
        case (d)
            2'd0:    return 32'd0;
            2'd1:    return lcgrr_pkg::LCG_MULT;
            2'd2:    return m2;
            default: return m2 + lcgrr_pkg::LCG_MULT;
        endcase
    endfunction

    always_comb begin
        n_sh   = r_sh;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_sh   = i_multiplicand;
            n_acc  = 32'd0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = {r_acc[31-lcgrr_pkg::DIGIT_W:0], {lcgrr_pkg::DIGIT_W{1'b0}}}
                    + mult_digit(r_sh[31:32-lcgrr_pkg::DIGIT_W]);
            n_sh  = {r_sh[31-lcgrr_pkg::DIGIT_W:0], {lcgrr_pkg::DIGIT_W{1'b0}}};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CntW'(lcgrr_pkg::MUL_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh  <= n_sh;
        r_acc <= n_acc;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_product  = r_acc;

endmodule

@@ rtl/lcgrr_rem.sv @@
// Restoring remainder unit: 16-bit dividend modulo a 17-bit divisor (1 to 65536),
// two dividend bits per cycle. Uses lcgrr_pkg.
module lcgrr_rem (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lcgrr_pkg::t_unit_ctl i_ctl,
    input  logic [15:0]          i_dividend,
    input  logic [16:0]          i_divisor,
    output lcgrr_pkg::t_unit_sts o_sts,
    output logic [15:0]          o_remainder
);

    localparam int CntW = $clog2(lcgrr_pkg::REM_STEPS);

    logic [15:0]     r_q, n_q;
    logic [16:0]     r_div, n_div;
    logic [16:0]     r_rem, n_rem;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [16:0]     w_mid;

    function automatic logic [16:0] rem_step(input logic [16:0] rem, input logic bit_in,
                                             input logic [16:0] divisor);
        logic [17:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, divisor}) begin
            t = t - {1'b0, divisor};
        end
        return t[16:0];
    endfunction

    always_comb begin
        n_q    = r_q;
        n_div  = r_div;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_mid  = rem_step(r_rem, r_q[15], r_div);
        if (i_ctl.start) begin
            n_q    = i_dividend;
            n_div  = i_divisor;
            n_rem  = 17'd0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = rem_step(w_mid, r_q[14], r_div);
            n_q   = {r_q[13:0], 2'b00};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CntW'(lcgrr_pkg::REM_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;
    assign o_remainder = r_rem[15:0];

endmodule

@@ rtl/lcg_random_range_top.sv @@
// 32-bit linear congruential generator with ranged draws, raw draws and reseed.
// Depends on lcgrr_pkg, lcgrr_if, lcgrr_mul, lcgrr_rem and the assertion macro header.
//
// One transaction in gives one transaction out. The block works on one item at a time
// and takes the next once the current result has been handed to the output register,
// which holds it until taken. A ranged draw with distinct bounds passes through decode
// and bound ordering, the two-bit-per-cycle state multiplier, the two-bit-per-cycle
// remainder unit and the final add; with a span above 65536 the remainder unit is
// skipped. A raw draw uses only the multiplier. Reseed, equal bounds and unused codes
// go from decode straight to the finish step.
// The generator state is zero after reset.
`include "lcg_random_range_top_defines.svh"

module lcg_random_range_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lcgrr_in_if.sink    i_in,
    lcgrr_out_if.source o_out
);

    lcgrr_pkg::t_state  r_state, n_state;
    lcgrr_pkg::t_op     r_op, n_op;
    logic signed [31:0] r_a, n_a;
    logic signed [31:0] r_b, n_b;
    logic [31:0]        r_seed, n_seed;
    logic signed [31:0] r_lo, n_lo;
    logic signed [31:0] r_hi, n_hi;
    logic [32:0]        r_diff, n_diff;
    logic [31:0]        r_gen, n_gen;
    logic signed [31:0] r_ranged, n_ranged;
    logic [15:0]        r_remv, n_remv;
    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_out_ranged, n_out_ranged;
    logic [31:0]        r_out_raw, n_out_raw;

    lcgrr_pkg::t_unit_ctl w_mul_ctl, w_rem_ctl;
    lcgrr_pkg::t_unit_sts w_mul_sts, w_rem_sts;
    logic [31:0]          w_product;
    logic [15:0]          w_remainder;
    logic [16:0]          w_span;

    lcgrr_mul u_mul (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_mul_ctl),
        .i_multiplicand (r_gen),
        .o_sts          (w_mul_sts),
        .o_product      (w_product)
    );

    lcgrr_rem u_rem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_rem_ctl),
        .i_dividend  (r_gen[31:lcgrr_pkg::DRAW_SHIFT]),
        .i_divisor   (w_span),
        .o_sts       (w_rem_sts),
        .o_remainder (w_remainder)
    );

    assign w_span     = {1'b0, r_diff[15:0]} + 17'd1;
    assign i_in.ready = (r_state == lcgrr_pkg::S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_a          = r_a;
        n_b          = r_b;
        n_seed       = r_seed;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_diff       = {r_hi[31], r_hi} - {r_lo[31], r_lo};
        n_gen        = r_gen;
        n_ranged     = r_ranged;
        n_remv       = r_remv;
        n_out_valid  = r_out_valid;
        n_out_ranged = r_out_ranged;
        n_out_raw    = r_out_raw;
        w_mul_ctl    = '0;
        w_rem_ctl    = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            lcgrr_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_op    = lcgrr_pkg::t_op'(i_in.operation);
                    n_a     = i_in.bound_a;
                    n_b     = i_in.bound_b;
                    n_seed  = i_in.seed_value;
                    n_state = lcgrr_pkg::S_DEC;
                end
            end
            lcgrr_pkg::S_DEC: begin
                n_ranged = 32'sd0;
                unique case (r_op)
                    lcgrr_pkg::OP_RANGED: begin
                        if (r_a == r_b) begin
                            n_ranged = r_a;
                            n_state  = lcgrr_pkg::S_FIN;
                        end else begin
                            n_lo            = (r_a < r_b) ? r_a : r_b;
                            n_hi            = (r_a < r_b) ? r_b : r_a;
                            w_mul_ctl.start = 1'b1;
                            n_state         = lcgrr_pkg::S_MUL;
                        end
                    end
                    lcgrr_pkg::OP_RAW: begin
                        w_mul_ctl.start = 1'b1;
                        n_state         = lcgrr_pkg::S_MUL;
                    end
                    lcgrr_pkg::OP_SEED: begin
                        n_gen   = r_seed;
                        n_state = lcgrr_pkg::S_FIN;
                    end
                    default: begin
                        n_state = lcgrr_pkg::S_FIN;
                    end
                endcase
            end
            lcgrr_pkg::S_MUL: begin
                if (w_mul_sts.done) begin
                    n_gen   = w_product + 32'd1;
                    n_state = (r_op == lcgrr_pkg::OP_RAW) ? lcgrr_pkg::S_FIN
                                                          : lcgrr_pkg::S_RSEL;
                end
            end
            lcgrr_pkg::S_RSEL: begin
                if (r_diff[32:16] != 17'd0) begin
                    n_remv  = r_gen[31:lcgrr_pkg::DRAW_SHIFT];
                    n_state = lcgrr_pkg::S_ADD;
                end else begin
                    w_rem_ctl.start = 1'b1;
                    n_state         = lcgrr_pkg::S_REM;
                end
            end
            lcgrr_pkg::S_REM: begin
                if (w_rem_sts.done) begin
                    n_remv  = w_remainder;
                    n_state = lcgrr_pkg::S_ADD;
                end
            end
            lcgrr_pkg::S_ADD: begin
                n_ranged = r_lo + $signed({16'h0000, r_remv});
                n_state  = lcgrr_pkg::S_FIN;
            end
            lcgrr_pkg::S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_ranged = r_ranged;
                    n_out_raw    = r_gen;
                    n_state      = lcgrr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lcgrr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcgrr_pkg::S_IDLE;
            r_gen       <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gen       <= n_gen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_a          <= n_a;
        r_b          <= n_b;
        r_seed       <= n_seed;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_diff       <= n_diff;
        r_ranged     <= n_ranged;
        r_remv       <= n_remv;
        r_out_ranged <= n_out_ranged;
        r_out_raw    <= n_out_raw;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.ranged_value = r_out_ranged;
    assign o_out.raw_value    = r_out_raw;

    `LCGRR_ASSERT(a_mul_done_in_mul, w_mul_sts.done |-> (r_state == lcgrr_pkg::S_MUL), "multiplier finished outside multiply state")
    `LCGRR_ASSERT(a_rem_done_in_rem, w_rem_sts.done |-> (r_state == lcgrr_pkg::S_REM), "remainder finished outside remainder state")
    `LCGRR_ASSERT(a_mul_alive, (r_state == lcgrr_pkg::S_MUL) |-> (w_mul_sts.busy || w_mul_sts.done), "waiting on an idle multiplier")
    `LCGRR_ASSERT_NEXT(a_seed_load, (r_state == lcgrr_pkg::S_DEC) && (r_op == lcgrr_pkg::OP_SEED), r_gen == $past(r_seed), "reseed not loaded")
    `LCGRR_ASSERT(a_out_from_fin, $rose(r_out_valid) |-> $past(r_state == lcgrr_pkg::S_FIN), "result raised outside finish state")

endmodule
